### hw/rtl/butterworth_highpass_iir5_top_macros.svh
// Assertion macros shared by the high-pass filter RTL.
`ifndef BUTTERWORTH_HIGHPASS_IIR5_TOP_MACROS_SVH
`define BUTTERWORTH_HIGHPASS_IIR5_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BHP_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed in %m");

// Next-cycle implication, disabled while reset is asserted.
`define BHP_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed in %m");

`endif

### hw/rtl/bhp_pkg.sv
// Fixed-point formats, coefficients and helper function of the high-pass filter.
package bhp_pkg;

	localparam int ORDER     = 5;
	localparam int COEF_FRAC = 24;
	localparam int COEF_W    = 29;
	localparam int IN_W      = 36;
	localparam int OUT_W     = 40;
	localparam int FIR_W     = 5;
	localparam int SPLIT     = 16;
	localparam int MUL_W     = OUT_W + COEF_W;
	localparam int PROD_W    = MUL_W - COEF_FRAC - 1;
	localparam int PSUM_W    = 48;
	localparam int GAIN_W    = 25;
	localparam int PH_W      = OUT_W - SPLIT + COEF_W;
	localparam int PL_W      = SPLIT + COEF_W + 1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [FIR_W-1:0]  fir_t;
	typedef logic signed [IN_W-1:0]   xhist_t;
	typedef logic signed [OUT_W-1:0]  yhist_t;
	typedef logic signed [PSUM_W-1:0] psum_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Reciprocal of the filter gain, Q24.
	localparam logic signed [GAIN_W-1:0] INV_GAIN = 25'sd13007654;

	// Entry k applies to the sample that is ORDER-k steps old.
	localparam coef_t FB_COEF [ORDER] = '{
		29'sd10085050, -29'sd55550160, 29'sd122676367, -29'sd135795716, 29'sd75360418
	};
	localparam fir_t FIR_COEF [ORDER] = '{
		-5'sd1, 5'sd5, -5'sd10, 5'sd10, -5'sd5
	};

	// round(y * c / 2^24), half up, built from two partial products.
	function automatic prod_t mul_round_coef(input yhist_t y, input coef_t c);
		logic signed [OUT_W-SPLIT-1:0]        yh;
		logic signed [SPLIT:0]                yl;
		logic signed [PH_W-1:0]               ph;
		logic signed [PL_W-1:0]               pl;
		logic signed [MUL_W-1:0]              t;
		logic signed [MUL_W-1:0]              half;
		yh   = y[OUT_W-1:SPLIT];
		yl   = {1'b0, y[SPLIT-1:0]};
		ph   = PH_W'(yh) * PH_W'(c);
		pl   = PL_W'(yl) * PL_W'(c);
		half = MUL_W'(1) << (COEF_FRAC - 1);
		t    = (MUL_W'(ph) <<< SPLIT) + MUL_W'(pl) + half;
		return t[MUL_W-2:COEF_FRAC];
	endfunction

endpackage

### hw/rtl/bhp_stream_ifs.sv
// Valid/ready stream interfaces for the filter's input and output samples.
interface bhp_in_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface bhp_out_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

### hw/rtl/bhp_cell.sv
// One cell of the transposed partial-sum chain: one numerator tap and one feedback tap.
module bhp_cell #(
	parameter int TAP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  bhp_pkg::xhist_t x,
	input  bhp_pkg::yhist_t y,
	input  bhp_pkg::psum_t  psum_in,
	output bhp_pkg::psum_t  psum_q
);
	import bhp_pkg::*;

	logic signed [IN_W+FIR_W-1:0] fir_p;
	prod_t                        fb_p;
	psum_t                        psum_d;

	always_comb begin
		fir_p  = (IN_W+FIR_W)'(x) * (IN_W+FIR_W)'(FIR_COEF[TAP]);
		fb_p   = mul_round_coef(y, FB_COEF[TAP]);
		psum_d = psum_in + PSUM_W'(fir_p) + PSUM_W'(fb_p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (en) begin
			psum_q <= psum_d;
		end
	end

endmodule

### hw/rtl/butterworth_highpass_iir5_top.sv
// Fifth-order Butterworth high-pass filter, direct form I, one sample per request.
// The result is registered and is valid in the cycle after its request is accepted.
// Throughput: one sample per cycle unless dout stalls; newest-output feedback loops via y_q.
// Older taps are folded into a chain of partial-sum cells updated on every accepted request.
// Reset clears both histories and all partial sums and empties the output register.
`include "butterworth_highpass_iir5_top_macros.svh"

module butterworth_highpass_iir5_top #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	bhp_in_if.sink    din,
	bhp_out_if.source dout
);
	import bhp_pkg::*;

	localparam int SH    = COEF_FRAC - FRACTION_BITS;
	localparam int XP_W  = SAMPLE_WIDTH + GAIN_W;
	localparam int CL_W  = (XP_W > IN_W) ? XP_W : IN_W;
	localparam int R_W   = OUT_W + 1 - FRACTION_BITS;
	localparam int CMP_W = (R_W > SAMPLE_WIDTH) ? R_W : SAMPLE_WIDTH;

	localparam logic signed [CL_W-1:0] XMAX = {{(CL_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}};
	localparam logic signed [CL_W-1:0] XMIN = ~XMAX;
	localparam logic signed [PSUM_W-1:0] YMAX = {{(PSUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [PSUM_W-1:0] YMIN = ~YMAX;
	localparam logic signed [OUT_W:0] Y_HALF = (OUT_W+1)'(1) << (FRACTION_BITS - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = ~OUT_MAX;
	localparam logic signed [CMP_W-1:0] SMAX = CMP_W'(OUT_MAX);
	localparam logic signed [CMP_W-1:0] SMIN = CMP_W'(OUT_MIN);

	logic                           acc_in;
	logic                           out_vld_q;
	logic signed [SAMPLE_WIDTH-1:0] samp_q;
	logic                           clip_q;
	xhist_t                         x_q;
	yhist_t                         y_q;

	logic signed [XP_W-1:0]         x_prod;
	logic signed [XP_W-1:0]         x_rnd;
	logic signed [CL_W-1:0]         x_ext;
	xhist_t                         xn;
	logic signed [IN_W+FIR_W-1:0]   x1_term;
	prod_t                          fb_last;
	psum_t                          acc;
	yhist_t                         y_new;
	logic signed [OUT_W:0]          y_rnd_sum;
	logic signed [R_W-1:0]          r;
	logic signed [CMP_W-1:0]        r_ext;
	logic signed [SAMPLE_WIDTH-1:0] samp_d;
	logic                           clip_d;

	psum_t chain_in [ORDER-1];
	psum_t chain_q  [ORDER-1];

	assign acc_in     = din.valid && din.ready;
	assign din.ready  = !out_vld_q || dout.ready;
	assign dout.valid      = out_vld_q;
	assign dout.sample_out = samp_q;
	assign dout.clipped    = clip_q;

	// Scale the raw sample by the reciprocal gain into the input history format.
	assign x_prod = XP_W'(din.sample_in) * XP_W'(INV_GAIN);

	generate
		if (SH > 0) begin : g_round_in
			localparam logic signed [XP_W-1:0] X_HALF = XP_W'(1) << (SH - 1);
			assign x_rnd = (x_prod + X_HALF) >>> SH;
		end else begin : g_exact_in
			assign x_rnd = x_prod;
		end
	endgenerate

	always_comb begin
		x_ext = CL_W'(x_rnd);
		if (x_ext > XMAX) begin
			xn = XMAX[IN_W-1:0];
		end else if (x_ext < XMIN) begin
			xn = XMIN[IN_W-1:0];
		end else begin
			xn = x_ext[IN_W-1:0];
		end
	end

	genvar k;
	generate
		for (k = 0; k < ORDER - 1; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign chain_in[k] = '0;
			end else begin : g_link
				assign chain_in[k] = chain_q[k-1];
			end
			bhp_cell #(.TAP(k)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (acc_in),
				.x       (x_q),
				.y       (y_q),
				.psum_in (chain_in[k]),
				.psum_q  (chain_q[k])
			);
		end
	endgenerate

	// The newest sample enters with unit weight; the one-step-old taps close the loop here.
	always_comb begin
		x1_term = (IN_W+FIR_W)'(x_q) * (IN_W+FIR_W)'(FIR_COEF[ORDER-1]);
		fb_last = mul_round_coef(y_q, FB_COEF[ORDER-1]);
		acc     = PSUM_W'(xn) + PSUM_W'(x1_term) + PSUM_W'(fb_last) + chain_q[ORDER-2];
		if (acc > YMAX) begin
			y_new = YMAX[OUT_W-1:0];
		end else if (acc < YMIN) begin
			y_new = YMIN[OUT_W-1:0];
		end else begin
			y_new = acc[OUT_W-1:0];
		end
		y_rnd_sum = (OUT_W+1)'(y_new) + Y_HALF;
		r         = y_rnd_sum[OUT_W:FRACTION_BITS];
		r_ext     = CMP_W'(r);
		if (r_ext > SMAX) begin
			samp_d = OUT_MAX;
			clip_d = 1'b1;
		end else if (r_ext < SMIN) begin
			samp_d = OUT_MIN;
			clip_d = 1'b1;
		end else begin
			samp_d = r_ext[SAMPLE_WIDTH-1:0];
			clip_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
		end else begin
			if (acc_in) begin
				out_vld_q <= 1'b1;
				x_q       <= xn;
				y_q       <= y_new;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			samp_q <= samp_d;
			clip_q <= clip_d;
		end
	end

	`BHP_ASSERT_NXT(a_result_follows, clk, arst_n, acc_in, out_vld_q)
	`BHP_ASSERT_NXT(a_state_holds, clk, arst_n, !acc_in, $stable(x_q) && $stable(y_q))
	`BHP_ASSERT_IMP(a_no_overwrite, clk, arst_n, out_vld_q && !dout.ready, !din.ready)
	`BHP_ASSERT_IMP(a_clip_at_rail, clk, arst_n, out_vld_q && clip_q, (samp_q == OUT_MAX) || (samp_q == OUT_MIN))

endmodule
